/* sv/olr_pkg.sv */
`default_nettype none

package olr_pkg;

	localparam int NAME_CHARS   = 8;
	localparam int ADDRESS_BITS = 24;
	localparam int GROUP_CHARS  = 6;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int FILL_W = $clog2(GROUP_CHARS + 1);
	localparam int GIDX_W = (GROUP_CHARS > 1) ? $clog2(GROUP_CHARS) : 1;

	localparam int OUT_ADDR_W  = 24;
	localparam int OUT_CHARS_W = 48;
	localparam int OUT_CNT_W   = 3;
	localparam int M_DATA_W    = 80;

	localparam logic REG_NAME     = 1'b0;
	localparam logic REG_NAME_LEN = 1'b1;

	typedef logic [ADDRESS_BITS-1:0] addr_t;
	typedef logic [GROUP_CHARS-1:0][7:0] group_t;

	typedef enum logic [2:0] {
		KIND_MATCH    = 3'd0,
		KIND_MISMATCH = 3'd1,
		KIND_CODE     = 3'd2,
		KIND_END_REC  = 3'd3,
		KIND_FILE_END = 3'd4
	} kind_t;

	typedef struct packed {
		kind_t                   kind;
		logic [OUT_ADDR_W-1:0]   addr;
		logic [OUT_CHARS_W-1:0]  chars;
		logic [OUT_CNT_W-1:0]    count;
		logic                    last;
	} result_t;

	typedef struct packed {
		logic [1:0] n;
		result_t    e0;
		result_t    e1;
	} push_t;

	function automatic logic [OUT_ADDR_W-1:0] out_addr(input addr_t a);
		logic [ADDRESS_BITS+OUT_ADDR_W-1:0] w;
		w = {{OUT_ADDR_W{1'b0}}, a};
		return w[OUT_ADDR_W-1:0];
	endfunction

	function automatic logic [OUT_CHARS_W-1:0] out_chars(input group_t g);
		logic [8*GROUP_CHARS+OUT_CHARS_W-1:0] w;
		w = {{OUT_CHARS_W{1'b0}}, g};
		return w[OUT_CHARS_W-1:0];
	endfunction

	function automatic logic [OUT_CNT_W-1:0] out_count(input logic [FILL_W-1:0] f);
		logic [FILL_W+OUT_CNT_W-1:0] w;
		w = {{OUT_CNT_W{1'b0}}, f};
		return w[OUT_CNT_W-1:0];
	endfunction

	function automatic result_t mk_result(input kind_t k, input logic [OUT_ADDR_W-1:0] a,
			input logic [OUT_CHARS_W-1:0] c, input logic [OUT_CNT_W-1:0] n);
		result_t r;
		r.kind  = k;
		r.addr  = a;
		r.chars = c;
		r.count = n;
		r.last  = 1'b0;
		return r;
	endfunction

endpackage

`default_nettype wire

/* sv/object_record_loader.sv */
`default_nettype none

// Object record loader: one character item is accepted per clock while the
// four-entry result queue has room for two results, so text streams run at one
// item per cycle; a result enters the queue when the item that causes it is
// accepted and then passes through the output register; an end-of-file item
// that also closes a name or a short group yields two results, which drain
// one per cycle through the output register while the master side is ready.

module object_record_loader import olr_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                wr_en,
	input  wire logic                wr_index,
	input  wire logic [63:0]         wr_data,
	input  wire logic                s_tvalid,
	output logic                     s_tready,
	input  wire logic [7:0]          s_tdata,   // char_byte
	input  wire logic                s_tlast,   // file_end
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [M_DATA_W-1:0]      m_tdata,   // load_address, code_chars, char_count
	output logic [2:0]               m_tuser,   // result_kind
	output logic                     m_tlast    // last_of_run
);

	push_t   push;
	logic    room;
	logic    head_valid;
	result_t head;
	logic    pop;

	assign s_tready = room;

	olr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (wr_en),
		.wr_index  (wr_index),
		.wr_data   (wr_data),
		.accept    (s_tvalid && room),
		.char_byte (s_tdata),
		.file_end  (s_tlast),
		.push      (push)
	);

	olr_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pop        (pop),
		.room       (room),
		.head_valid (head_valid),
		.head       (head)
	);

	olr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata),
		.m_tuser    (m_tuser),
		.m_tlast    (m_tlast)
	);

endmodule

`default_nettype wire

/* sv/olr_front.sv */
`default_nettype none

module olr_front import olr_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        wr_en,
	input  wire logic        wr_index,
	input  wire logic [63:0] wr_data,
	input  wire logic        accept,
	input  wire logic [7:0]  char_byte,
	input  wire logic        file_end,
	output push_t            push
);

	typedef enum logic [2:0] {
		PH_AWAIT_HDR,
		PH_HDR_NAME,
		PH_HDR_REST,
		PH_AWAIT_REC,
		PH_SKIP_REC,
		PH_TEXT,
		PH_STOPPED
	} phase_t;

	localparam logic [1:0] TP_BODY = 2'd2;
	localparam logic [3:0] NAME_MAX = 4'(NAME_CHARS);
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(GROUP_CHARS);
	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_T = 8'h54;
	localparam logic [7:0] CH_E = 8'h45;

	logic [63:0]       exp_name_q;
	logic [3:0]        exp_len_q;
	phase_t            phase_q, phase_n;
	logic [1:0]        tp_q, tp_n;
	logic [3:0]        idx_q, idx_n;
	logic              eq_q, eq_n;
	addr_t             addr_q, addr_n;
	logic              hex_stop_q, hex_stop_n;
	logic [1:0]        caret_q, caret_n;
	group_t            grp_q, grp_n;
	logic [FILL_W-1:0] fill_q, fill_n;

	logic [3:0] limit;
	logic       ws;
	logic       name_acc;
	logic [7:0] want;
	logic [4:0] hex_d;
	logic [1:0] tp_inc;
	logic       a_v, b_v;
	result_t    a_r, b_r;
	result_t    flush_r;

	function automatic logic [4:0] hex_value(input logic [7:0] c);
		logic [4:0] v;
		v = 5'h10;
		if (c >= 8'h30 && c <= 8'h39) v = {1'b0, 4'(c - 8'h30)};
		else if (c >= 8'h41 && c <= 8'h46) v = {1'b0, 4'(c - 8'h37)};
		else if (c >= 8'h61 && c <= 8'h66) v = {1'b0, 4'(c - 8'h57)};
		return v;
	endfunction

	assign limit    = (exp_len_q > NAME_MAX) ? NAME_MAX : exp_len_q;
	assign ws       = (char_byte == 8'h20) || (char_byte >= 8'h09 && char_byte <= 8'h0D);
	assign name_acc = eq_q && (idx_q == limit);
	assign want     = exp_name_q[8*(7 - idx_q[2:0]) +: 8];
	assign hex_d    = hex_value(char_byte);
	assign tp_inc   = (tp_q == TP_BODY) ? TP_BODY : tp_q + 2'd1;
	assign flush_r  = mk_result(KIND_CODE, out_addr(addr_q), out_chars(grp_q), out_count(fill_q));

	always_comb begin
		phase_n    = phase_q;
		tp_n       = tp_q;
		idx_n      = idx_q;
		eq_n       = eq_q;
		addr_n     = addr_q;
		hex_stop_n = hex_stop_q;
		caret_n    = caret_q;
		grp_n      = grp_q;
		fill_n     = fill_q;
		a_v        = 1'b0;
		b_v        = 1'b0;
		a_r        = mk_result(name_acc ? KIND_MATCH : KIND_MISMATCH, '0, '0, '0);
		b_r        = mk_result(KIND_FILE_END, '0, '0, '0);

		if (file_end) begin
			if (phase_q == PH_HDR_NAME) begin
				a_v = 1'b1;
			end else if (phase_q == PH_TEXT && fill_q != '0) begin
				a_v = 1'b1;
				a_r = flush_r;
			end
			b_v        = 1'b1;
			phase_n    = PH_AWAIT_HDR;
			tp_n       = '0;
			idx_n      = '0;
			eq_n       = 1'b1;
			addr_n     = '0;
			hex_stop_n = 1'b0;
			caret_n    = '0;
			grp_n      = '0;
			fill_n     = '0;
		end else begin
			case (phase_q)
				PH_AWAIT_HDR: begin
					if (!ws) begin
						phase_n = PH_HDR_NAME;
						tp_n    = 2'd1;
					end
				end
				PH_HDR_NAME: begin
					if (ws || (tp_q == TP_BODY && char_byte == CH_CARET)) begin
						a_v = 1'b1;
						if (!name_acc) phase_n = PH_STOPPED;
						else phase_n = ws ? PH_AWAIT_REC : PH_HDR_REST;
					end else begin
						if (tp_q == TP_BODY) begin
							if (!(idx_q < limit) || want != char_byte) eq_n = 1'b0;
							if (idx_q != 4'hF) idx_n = idx_q + 4'd1;
						end
						tp_n = tp_inc;
					end
				end
				PH_HDR_REST, PH_SKIP_REC: begin
					if (ws) phase_n = PH_AWAIT_REC;
				end
				PH_AWAIT_REC: begin
					if (!ws) begin
						if (char_byte == CH_T) begin
							phase_n    = PH_TEXT;
							tp_n       = 2'd1;
							addr_n     = '0;
							hex_stop_n = 1'b0;
							caret_n    = '0;
							grp_n      = '0;
							fill_n     = '0;
						end else if (char_byte == CH_E) begin
							a_v     = 1'b1;
							a_r     = mk_result(KIND_END_REC, '0, '0, '0);
							phase_n = PH_STOPPED;
						end else begin
							phase_n = PH_SKIP_REC;
						end
					end
				end
				PH_TEXT: begin
					if (ws) begin
						phase_n = PH_AWAIT_REC;
						if (fill_q != '0) begin
							a_v    = 1'b1;
							a_r    = flush_r;
							addr_n = addr_q + ADDRESS_BITS'(3);
							grp_n  = '0;
							fill_n = '0;
						end
					end else begin
						tp_n = tp_inc;
						if (tp_q == TP_BODY) begin
							if (caret_q == 2'd0) begin
								if (char_byte == CH_CARET) begin
									caret_n = 2'd1;
								end else if (!hex_stop_q) begin
									if (hex_d[4]) hex_stop_n = 1'b1;
									else addr_n = {addr_q[ADDRESS_BITS-5:0], hex_d[3:0]};
								end
							end else if (caret_q == 2'd1) begin
								if (char_byte == CH_CARET) caret_n = 2'd2;
							end else if (!(fill_q == '0 && char_byte == CH_CARET)) begin
								grp_n[GIDX_W'(GROUP_CHARS - 1) - fill_q[GIDX_W-1:0]] = char_byte;
								fill_n = fill_q + FILL_W'(1);
								if (fill_n == FILL_FULL) begin
									a_v    = 1'b1;
									a_r    = mk_result(KIND_CODE, out_addr(addr_q),
										out_chars(grp_n), out_count(FILL_FULL));
									addr_n = addr_q + ADDRESS_BITS'(3);
									grp_n  = '0;
									fill_n = '0;
								end
							end
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		push = '0;
		if (accept) begin
			if (a_v && b_v) begin
				push.n       = 2'd2;
				push.e0      = a_r;
				push.e1      = b_r;
				push.e1.last = 1'b1;
			end else if (a_v) begin
				push.n       = 2'd1;
				push.e0      = a_r;
				push.e0.last = 1'b1;
			end else if (b_v) begin
				push.n       = 2'd1;
				push.e0      = b_r;
				push.e0.last = 1'b1;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			exp_name_q <= '0;
			exp_len_q  <= '0;
			phase_q    <= PH_AWAIT_HDR;
			tp_q       <= '0;
			idx_q      <= '0;
			eq_q       <= 1'b1;
			addr_q     <= '0;
			hex_stop_q <= 1'b0;
			caret_q    <= '0;
			grp_q      <= '0;
			fill_q     <= '0;
		end else begin
			if (wr_en) begin
				if (wr_index == REG_NAME_LEN) exp_len_q <= wr_data[3:0];
				else exp_name_q <= wr_data;
			end
			if (accept) begin
				phase_q    <= phase_n;
				tp_q       <= tp_n;
				idx_q      <= idx_n;
				eq_q       <= eq_n;
				addr_q     <= addr_n;
				hex_stop_q <= hex_stop_n;
				caret_q    <= caret_n;
				grp_q      <= grp_n;
				fill_q     <= fill_n;
			end
		end
	end

endmodule

`default_nettype wire

/* sv/olr_queue.sv */
`default_nettype none

module olr_queue import olr_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire push_t push,
	input  wire logic  pop,
	output logic       room,
	output logic       head_valid,
	output result_t    head
);

	result_t           mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;
	logic [QPTR_W-1:0] wr_ptr_p1;

	assign wr_ptr_p1  = wr_ptr_q + QPTR_W'(1);
	assign room       = cnt_q <= QCNT_W'(QUEUE_DEPTH - 2);
	assign head_valid = cnt_q != '0;
	assign head       = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push.n != 2'd0) mem_q[wr_ptr_q] <= push.e0;
		if (push.n == 2'd2) mem_q[wr_ptr_p1] <= push.e1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + QPTR_W'(push.n);
			if (pop) rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			cnt_q <= cnt_q + QCNT_W'(push.n) - QCNT_W'(pop);
		end
	end

`ifndef ASSERT_OFF
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push.n != 2'd0 |-> room)
		else $error("queue written without room for two items");
	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid)
		else $error("queue read while empty");
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QCNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");
	a_pair_last: assert property (@(posedge clk) disable iff (!arst_n)
		push.n == 2'd2 |-> push.e1.last && !push.e0.last)
		else $error("paired results carry a wrong last flag");
`endif

endmodule

`default_nettype wire

/* sv/olr_back.sv */
`default_nettype none

module olr_back import olr_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                head_valid,
	input  wire result_t             head,
	output logic                     pop,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output logic [M_DATA_W-1:0]      m_tdata,
	output logic [2:0]               m_tuser,
	output logic                     m_tlast
);

	logic    valid_q;
	result_t res_q;

	assign pop      = head_valid && (!valid_q || m_tready);
	assign m_tvalid = valid_q;
	assign m_tuser  = res_q.kind;
	assign m_tlast  = res_q.last;
	assign m_tdata  = {(M_DATA_W - OUT_CNT_W - OUT_CHARS_W - OUT_ADDR_W)'(0),
		res_q.count, res_q.chars, res_q.addr};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) res_q <= head;
	end

endmodule

`default_nettype wire

/* tb/object_record_loader_tb.sv */
`timescale 1ns / 100ps

module object_record_loader_tb;
	import olr_pkg::*;

	localparam logic [7:0] CH_CARET = 8'h5E;
	localparam logic [7:0] CH_TEXT  = 8'h54;
	localparam logic [7:0] CH_END   = 8'h45;
	localparam logic [7:0] CH_HEAD  = 8'h48;
	localparam logic [7:0] CH_SPACE = 8'h20;

	typedef enum logic [2:0] {
		WAIT_HEADER,
		HEADER_NAME,
		HEADER_REST,
		WAIT_RECORD,
		SKIP_RECORD,
		TEXT_RECORD,
		STOPPED
	} parse_phase_e;

	logic                clk;
	logic                arst_n;
	logic                wr_en;
	logic                wr_index;
	logic [63:0]         wr_data;
	logic                s_tvalid;
	logic                s_tready;
	logic [7:0]          s_tdata;
	logic                s_tlast;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;
	logic [2:0]          m_tuser;
	logic                m_tlast;

	result_t     expected_results[$];
	logic [7:0]  file_bytes[$];
	int          errors = 0;
	int          items_counted = 0;
	int          item_results;
	int          sink_hold = 0;
	bit          steady = 1'b0;

	logic [63:0]  cfg_name;
	logic [3:0]   cfg_len;
	parse_phase_e phase;
	int           token_pos;
	int           name_idx;
	int           caret_count;
	int           group_fill;
	bit           name_ok;
	bit           name_taken;
	bit           hex_done;
	logic [23:0]  load_addr;
	logic [47:0]  group_chars;

	object_record_loader i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("object_record_loader_tb NOT OK");
		$finish;
	end

	function automatic bit is_space(input logic [7:0] c);
		return c == CH_SPACE || (c >= 8'h09 && c <= 8'h0D);
	endfunction

	function automatic int hex_value(input logic [7:0] c);
		if (c >= 8'h30 && c <= 8'h39) return int'(c) - 'h30;
		if (c >= 8'h41 && c <= 8'h46) return int'(c) - 'h41 + 10;
		if (c >= 8'h61 && c <= 8'h66) return int'(c) - 'h61 + 10;
		return -1;
	endfunction

	function automatic int name_limit();
		return (cfg_len > 4'd8) ? 8 : int'(cfg_len);
	endfunction

	task automatic clear_parser();
		phase = WAIT_HEADER;
		token_pos = 0;
		name_idx = 0;
		name_ok = 1'b1;
		name_taken = 1'b0;
		load_addr = '0;
		hex_done = 1'b0;
		caret_count = 0;
		group_chars = '0;
		group_fill = 0;
	endtask

	task automatic push_result(input kind_t kind, input logic [23:0] addr,
			input logic [47:0] chars, input logic [2:0] count);
		result_t r;
		r = '0;
		r.kind = kind;
		r.addr = addr;
		r.chars = chars;
		r.count = count;
		expected_results.push_back(r);
		item_results++;
	endtask

	task automatic resolve_name();
		name_taken = name_ok && name_idx == name_limit();
		push_result(name_taken ? KIND_MATCH : KIND_MISMATCH, '0, '0, '0);
	endtask

	task automatic flush_group();
		if (group_fill != 0) begin
			push_result(KIND_CODE, load_addr, group_chars << (8 * (GROUP_CHARS - group_fill)),
				3'(group_fill));
			load_addr = load_addr + 24'd3;
			group_chars = '0;
			group_fill = 0;
		end
	endtask

	task automatic text_char(input logic [7:0] c);
		int d;
		if (token_pos < 2) begin
			return;
		end
		if (caret_count == 0) begin
			if (c == CH_CARET) begin
				caret_count = 1;
			end else if (!hex_done) begin
				d = hex_value(c);
				if (d < 0) hex_done = 1'b1;
				else load_addr = {load_addr[19:0], 4'(d)};
			end
		end else if (caret_count == 1) begin
			if (c == CH_CARET) caret_count = 2;
		end else if (!(group_fill == 0 && c == CH_CARET)) begin
			group_chars = {group_chars[39:0], c};
			group_fill++;
			if (group_fill >= GROUP_CHARS) flush_group();
		end
	endtask

	task automatic predict_loader(input logic [7:0] c, input logic eof);
		bit ws;
		item_results = 0;
		items_counted++;
		ws = is_space(c);
		if (eof) begin
			if (phase == HEADER_NAME) resolve_name();
			else if (phase == TEXT_RECORD) flush_group();
			push_result(KIND_FILE_END, '0, '0, '0);
			clear_parser();
		end else begin
			case (phase)
				WAIT_HEADER: begin
					if (!ws) begin
						phase = HEADER_NAME;
						token_pos = 1;
					end
				end
				HEADER_NAME: begin
					if (ws || (token_pos >= 2 && c == CH_CARET)) begin
						resolve_name();
						if (!name_taken) phase = STOPPED;
						else phase = ws ? WAIT_RECORD : HEADER_REST;
					end else begin
						if (token_pos >= 2) begin
							if (name_idx >= name_limit() ||
									cfg_name[63 - 8 * name_idx -: 8] != c)
								name_ok = 1'b0;
							if (name_idx < 15) name_idx++;
						end
						if (token_pos < 255) token_pos++;
					end
				end
				HEADER_REST, SKIP_RECORD: begin
					if (ws) phase = WAIT_RECORD;
				end
				WAIT_RECORD: begin
					if (!ws) begin
						if (c == CH_TEXT) begin
							phase = TEXT_RECORD;
							token_pos = 1;
							load_addr = '0;
							hex_done = 1'b0;
							caret_count = 0;
							group_chars = '0;
							group_fill = 0;
						end else if (c == CH_END) begin
							push_result(KIND_END_REC, '0, '0, '0);
							phase = STOPPED;
						end else begin
							phase = SKIP_RECORD;
						end
					end
				end
				TEXT_RECORD: begin
					if (ws) begin
						flush_group();
						phase = WAIT_RECORD;
					end else begin
						text_char(c);
						if (token_pos < 255) token_pos++;
					end
				end
				default: ;
			endcase
		end
		if (item_results > 0) expected_results[expected_results.size() - 1].last = 1'b1;
	endtask

	task automatic report_mismatch(input string field, input logic [63:0] got,
			input logic [63:0] want);
		if (errors < 100)
			$display("%0t ns: %s mismatch: got %0h, expected %0h", $realtime, field, got, want);
		errors++;
	endtask

	always @(posedge clk) begin : result_check
		result_t want;
		if (m_tvalid && m_tready) begin
			if (expected_results.size() == 0) begin
				report_mismatch("unexpected result, kind", 64'(m_tuser), '0);
			end else begin
				want = expected_results.pop_front();
				if (m_tuser !== want.kind)
					report_mismatch("result_kind", 64'(m_tuser), 64'(want.kind));
				if (m_tdata[23:0] !== want.addr)
					report_mismatch("load_address", 64'(m_tdata[23:0]), 64'(want.addr));
				if (m_tdata[71:24] !== want.chars)
					report_mismatch("code_chars", 64'(m_tdata[71:24]), 64'(want.chars));
				if (m_tdata[74:72] !== want.count)
					report_mismatch("char_count", 64'(m_tdata[74:72]), 64'(want.count));
				if (m_tlast !== want.last)
					report_mismatch("last_of_run", 64'(m_tlast), 64'(want.last));
			end
		end
	end

	initial begin : result_sink
		int stall;
		m_tready <= 1'b0;
		@(posedge clk);
		forever begin
			if (sink_hold > 0) begin
				stall = sink_hold;
				sink_hold = 0;
			end else if (steady) begin
				stall = 0;
			end else begin
				stall = $urandom_range(0, 9);
			end
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!(m_tvalid && m_tready) && sink_hold == 0);
		end
	end

	task automatic send_item(input logic [7:0] ch, input logic eof);
		int gap;
		gap = steady ? 0 : $urandom_range(0, 9);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= ch;
		s_tlast <= eof;
		do @(posedge clk); while (!s_tready);
		predict_loader(ch, eof);
	endtask

	task automatic send_eof();
		send_item(8'($urandom_range(0, 255)), 1'b1);
	endtask

	task automatic send_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++) send_item(s[i], 1'b0);
	endtask

	task automatic drain_results();
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic write_config(input logic [63:0] name, input logic [3:0] len);
		drain_results();
		wr_en <= 1'b1;
		wr_index <= REG_NAME;
		wr_data <= name;
		@(posedge clk);
		wr_index <= REG_NAME_LEN;
		wr_data <= 64'(len);
		@(posedge clk);
		wr_en <= 1'b0;
		cfg_name = name;
		cfg_len = len;
	endtask

	function automatic logic [7:0] hex_ascii(input int v);
		if (v < 10) return 8'(8'h30 + v);
		return 8'(($urandom_range(0, 1) ? 8'h41 : 8'h61) + v - 10);
	endfunction

	function automatic logic [7:0] ws_char();
		int r;
		r = $urandom_range(8, 13);
		return (r == 8) ? CH_SPACE : 8'(r);
	endfunction

	function automatic logic [7:0] solid_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(0, 255)); while (is_space(b));
		return b;
	endfunction

	function automatic logic [7:0] code_byte();
		case ($urandom_range(0, 15))
			0: return CH_CARET;
			1: return solid_byte();
			default: return hex_ascii($urandom_range(0, 15));
		endcase
	endfunction

	function automatic logic [7:0] noise_byte();
		case ($urandom_range(0, 7))
			0: return ws_char();
			1: return CH_CARET;
			2: return CH_TEXT;
			3: return CH_END;
			4: return CH_HEAD;
			5: return hex_ascii($urandom_range(0, 15));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic logic [63:0] random_name();
		logic [63:0] n;
		logic [7:0]  b;
		int          k;
		for (k = 0; k < 8; k++) begin
			do b = 8'($urandom_range(33, 255)); while (b == CH_CARET);
			n[63 - 8 * k -: 8] = b;
		end
		return n;
	endfunction

	task automatic put_byte(input logic [7:0] b);
		file_bytes.push_back(b);
	endtask

	task automatic put_hex_run(input int n);
		repeat (n) put_byte(hex_ascii($urandom_range(0, 15)));
	endtask

	task automatic build_good_file();
		int         variant;
		int         lim;
		int         n;
		int         k;
		int         g;
		int         groups;
		int         glen;
		logic [7:0] b;
		file_bytes.delete();
		lim = name_limit();
		put_byte(CH_HEAD);
		put_byte(solid_byte());
		variant = $urandom_range(0, 9);
		n = lim;
		if (variant == 1) n = lim + 1;
		if (variant == 2 && lim > 0) n = lim - 1;
		for (k = 0; k < n; k++) begin
			b = (k < lim) ? cfg_name[63 - 8 * k -: 8] : 8'h58;
			if (variant == 0 && k == n - 1) b = b ^ 8'h01;
			put_byte(b);
		end
		if ($urandom_range(0, 3) != 0) begin
			put_byte(CH_CARET);
			put_hex_run(6);
			put_byte(CH_CARET);
			put_hex_run(6);
		end
		put_byte(ws_char());
		repeat ($urandom_range(0, 4)) begin
			if ($urandom_range(0, 9) == 0) begin
				put_byte(8'($urandom_range(8'h41, 8'h53)));
				put_hex_run($urandom_range(0, 8));
			end else begin
				put_byte(CH_TEXT);
				put_byte(hex_ascii($urandom_range(0, 15)));
				case ($urandom_range(0, 7))
					0: put_hex_run($urandom_range(0, 9));
					1: begin
						put_hex_run(3);
						put_byte(8'h7A);
						put_hex_run(2);
					end
					default: put_hex_run(6);
				endcase
				if ($urandom_range(0, 9) != 0) begin
					put_byte(CH_CARET);
					put_hex_run(2);
					put_byte(CH_CARET);
					groups = $urandom_range(0, 5);
					for (g = 0; g < groups; g++) begin
						glen = (g == groups - 1 && $urandom_range(0, 1)) ?
							$urandom_range(1, 5) : 6;
						repeat (glen) put_byte(code_byte());
						if (g < groups - 1) put_byte(CH_CARET);
					end
				end
			end
			repeat ($urandom_range(1, 2)) put_byte(ws_char());
		end
		if ($urandom_range(0, 4) != 0) begin
			put_byte(CH_END);
			put_hex_run(6);
			put_byte(ws_char());
			if ($urandom_range(0, 3) == 0) begin
				put_byte(CH_TEXT);
				put_hex_run(7);
			end
		end
	endtask

	task automatic send_file(input int cut, input int pause_at);
		int i;
		for (i = 0; i < cut; i++) begin
			if (i == pause_at) drain_results();
			send_item(file_bytes[i], 1'b0);
		end
		send_eof();
	endtask

	task automatic test_header_forms();
		write_config(64'hFFFF_FFFF_FFFF_FFFF, 4'd0);
		send_text("H");
		send_eof();
		write_config({"AB", 48'h0}, 4'd2);
		send_text("H^ABC T");
		send_eof();
	endtask

	task automatic test_text_records();
		send_text("H^AB Q T5 T01ffFFFFFz3^^AB^CDE^FG E");
		send_eof();
		send_text("H^AB^0 T0fg1^^ABCDEFGH");
		send_eof();
	endtask

	task automatic test_output_backpressure();
		int k;
		write_config("LOADPROG", 4'd8);
		steady = 1'b1;
		sink_hold = 300;
		send_text("H^LOADPROG^000000^000030 T000000^30^");
		for (k = 0; k < 48; k++) send_item(hex_ascii(k % 16), 1'b0);
		send_text(" E000000");
		send_eof();
		steady = 1'b0;
	endtask

	task automatic test_drain_pause();
		build_good_file();
		send_file(file_bytes.size(), file_bytes.size() / 2);
	endtask

	task automatic test_random_files();
		int round;
		int quota;
		int mode;
		for (round = 0; round < 6; round++) begin
			case (round)
				0: write_config(random_name(), 4'd8);
				1: write_config(64'h0, 4'd0);
				2: write_config(random_name(), 4'd1);
				default: write_config(random_name(), 4'($urandom_range(1, 7)));
			endcase
			quota = items_counted + 230;
			while (items_counted < quota) begin
				mode = $urandom_range(0, 9);
				steady = ($urandom_range(0, 5) == 0);
				if (mode == 0) begin
					file_bytes.delete();
					repeat ($urandom_range(1, 30)) put_byte(noise_byte());
					send_file(file_bytes.size(), -1);
				end else begin
					build_good_file();
					if (mode == 1)
						send_file($urandom_range(0, file_bytes.size()), -1);
					else if (mode == 2)
						send_file(file_bytes.size(), $urandom_range(0, file_bytes.size() - 1));
					else
						send_file(file_bytes.size(), -1);
				end
			end
		end
		steady = 1'b0;
	endtask

	initial begin
		arst_n <= 1'b0;
		wr_en <= 1'b0;
		wr_index <= REG_NAME;
		wr_data <= '0;
		s_tvalid <= 1'b0;
		s_tdata <= '0;
		s_tlast <= 1'b0;
		cfg_name = '0;
		cfg_len = '0;
		clear_parser();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_header_forms();
		test_text_records();
		test_output_backpressure();
		test_drain_pause();
		test_random_files();
		drain_results();
		repeat (16) @(posedge clk);
		if (errors == 0) begin
			$display("object_record_loader_tb OK");
		end else begin
			$display("object_record_loader_tb NOT OK");
		end
		$finish;
	end

endmodule
